### src/linear_blend_vertex_skinning_assert.svh
// assertion macros for the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
// property a implies b on the next clock
`define LBS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// property a implies b in the same clock
`define LBS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

### src/lbs_pkg.sv
// shared types and constants for the skinning block
package lbs_pkg;
   localparam int NumBonesDefault  = 128;
   localparam int InfluencesDefault = 4;
   localparam int WordsPerBone     = 16;
   localparam int MinTotalWeight   = 33;
   localparam int AccWidth         = 100;

   typedef enum logic [0:0] {
      FUNC_WRITE = 1'b0,
      FUNC_SKIN  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_ACC_HIGH,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request item
      logic write_mem;  // perform matrix word write
      logic read;       // issue read of the current word
      logic mul;        // multiply stage
      logic acc;        // accumulate lower partial product
      logic acc_high;   // accumulate upper partial product
      logic clear;      // clear accumulators
      logic finish;     // form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic active;      // current influence counts
   } status_type;
endpackage

### src/lbs_if.sv
// valid ready channels for the skinning block
interface lbs_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  func;
   logic [6:0]  bone_index;
   logic [3:0]  element_index;
   logic signed [31:0] element_value;
   logic [23:0] vertex_tag;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [31:0] bone_ids_packed;
   logic [63:0] weights_packed;
   modport source (output valid, func, bone_index, element_index, element_value,
      vertex_tag, pos_x, pos_y, pos_z, bone_ids_packed, weights_packed, input ready);
   modport sink (input valid, func, bone_index, element_index, element_value,
      vertex_tag, pos_x, pos_y, pos_z, bone_ids_packed, weights_packed, output ready);
endinterface

interface lbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] vertex_tag_out;
   logic signed [31:0] skinned_x;
   logic signed [31:0] skinned_y;
   logic signed [31:0] skinned_z;
   logic        used_fallback;
   modport source (output valid, vertex_tag_out, skinned_x, skinned_y, skinned_z,
      used_fallback, input ready);
   modport sink (input valid, vertex_tag_out, skinned_x, skinned_y, skinned_z,
      used_fallback, output ready);
endinterface

### src/lbs_ctrl.sv
// controller state machine: sequences words, rows and influences
module lbs_ctrl
   import lbs_pkg::*;
#(
   parameter int INFLUENCES = InfluencesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic [1:0] infl,
   output logic [1:0] row,
   output logic [1:0] col
);
   state_type state_ff, state_in;
   logic [1:0] infl_ff, infl_in, row_ff, row_in, col_ff, col_in;
   logic rsp_valid_ff, rsp_valid_in;

   localparam logic [1:0] LastInfl = 2'(INFLUENCES - 1);

   assign infl = infl_ff;
   assign row = row_ff;
   assign col = col_ff;
   assign rsp_valid = rsp_valid_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         infl_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         infl_ff <= infl_in;
         row_ff <= row_in;
         col_ff <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state; each word steps through read, multiply, low and high accumulate
   always_comb begin
      state_in = state_ff;
      infl_in = infl_ff;
      row_in = row_ff;
      col_in = col_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.clear = 1'b1;
               infl_in = '0;
               row_in = '0;
               col_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.is_write) begin
               cmd.write_mem = 1'b1;
               state_in = ST_IDLE;
            end else if (!status.active) begin
               if (infl_ff == LastInfl) state_in = ST_DONE;
               else infl_in = infl_ff + 2'd1;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            state_in = ST_ACC_HIGH;
         end
         ST_ACC_HIGH: begin
            cmd.acc_high = 1'b1;
            state_in = ST_READ;
            col_in = col_ff + 2'd1;
            if (col_ff == 2'd3) begin
               col_in = '0;
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) begin
                  row_in = '0;
                  if (infl_ff == LastInfl) state_in = ST_DONE;
                  else infl_in = infl_ff + 2'd1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### src/lbs_dp.sv
// datapath: matrix memory, weighted multiply and accumulate, rounding
module lbs_dp
   import lbs_pkg::*;
#(
   parameter int NUM_BONES = NumBonesDefault
) (
   input  logic        clock,
   input  cmd_type     cmd,
   input  logic [1:0]  infl,
   input  logic [1:0]  row,
   input  logic [1:0]  col,
   input  logic [0:0]  req_func,
   input  logic [6:0]  req_bone_index,
   input  logic [3:0]  req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic [23:0] req_vertex_tag,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0] req_bone_ids_packed,
   input  logic [63:0] req_weights_packed,
   output status_type  status,
   output logic [23:0] rsp_vertex_tag_out,
   output logic signed [31:0] rsp_skinned_x,
   output logic signed [31:0] rsp_skinned_y,
   output logic signed [31:0] rsp_skinned_z,
   output logic        rsp_used_fallback
);
   localparam int Depth = NUM_BONES * WordsPerBone;
   localparam int AddrW = $clog2(Depth);

   logic [31:0] mem [Depth];
   logic [0:0]  func_ff;
   logic [6:0]  bone_ff;
   logic [3:0]  elem_ff;
   logic [31:0] value_ff;
   logic [23:0] tag_ff;
   logic signed [31:0] pos_ff [3];
   logic [31:0] ids_ff;
   logic [63:0] wts_ff;
   logic [31:0] rd_ff;
   logic signed [47:0] wm_ff;
   logic signed [31:0] p_ff;
   logic signed [AccWidth-1:0] acc_ff [3];
   logic [17:0] total_ff;
   logic [23:0] tag_out_ff;
   logic signed [31:0] out_ff [3];
   logic fb_ff;

   logic [7:0]  id_cur;
   logic [15:0] w_cur;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic signed [56:0] prod_lo;
   logic signed [55:0] prod_hi;
   logic [AccWidth-1:0] rnd [3];
   logic signed [31:0] sat [3];

   assign id_cur = ids_ff[8*infl +: 8];
   assign w_cur = wts_ff[16*infl +: 16];
   assign status.is_write = (func_ff == FUNC_WRITE);
   assign status.active = (32'(id_cur) < 32'(NUM_BONES)) && (w_cur != 16'd0);
   assign rd_addr = AddrW'({id_cur, col, row});
   assign wr_addr = AddrW'({bone_ff, elem_ff});

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         bone_ff <= req_bone_index;
         elem_ff <= req_element_index;
         value_ff <= req_element_value;
         tag_ff <= req_vertex_tag;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         ids_ff <= req_bone_ids_packed;
         wts_ff <= req_weights_packed;
      end
   end

   // matrix memory
   always_ff @(posedge clock) begin
      if (cmd.write_mem && (32'(bone_ff) < 32'(NUM_BONES))) mem[wr_addr] <= value_ff;
      if (cmd.read) rd_ff <= mem[rd_addr];
   end

   // weight times matrix word, and select position operand
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         wm_ff <= 48'($signed({1'b0, w_cur}) * $signed(rd_ff));
         p_ff <= (col == 2'd3) ? 32'sd65536 : pos_ff[col];
      end
   end

   // operand times weighted word, as an unsigned low half and a signed high half
   assign prod_lo = 57'($signed({1'b0, wm_ff[23:0]})) * 57'(p_ff);
   assign prod_hi = 56'($signed(wm_ff[47:24])) * 56'(p_ff);

   // accumulate into the row as a low and a high half, and total the weight
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         for (int r = 0; r < 3; r++) acc_ff[r] <= '0;
         total_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff[row] <= acc_ff[row] + AccWidth'(prod_lo);
         if (row == 2'd0 && col == 2'd0) total_ff <= total_ff + 18'(w_cur);
      end else if (cmd.acc_high) begin
         acc_ff[row] <= acc_ff[row] + (AccWidth'(prod_hi) <<< 24);
      end
   end

   // round to nearest, saturate
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rnd[r] = acc_ff[r] + (AccWidth'(1) << 30);
         if (rnd[r][AccWidth-1:62] == '0 || rnd[r][AccWidth-1:62] == '1)
            sat[r] = rnd[r][62:31];
         else
            sat[r] = rnd[r][AccWidth-1] ? 32'sh80000000 : 32'sh7fffffff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         tag_out_ff <= tag_ff;
         fb_ff <= total_ff < 18'(MinTotalWeight);
         for (int r = 0; r < 3; r++)
            out_ff[r] <= (total_ff < 18'(MinTotalWeight)) ? pos_ff[r] : sat[r];
      end
   end

   assign rsp_vertex_tag_out = tag_out_ff;
   assign rsp_skinned_x = out_ff[0];
   assign rsp_skinned_y = out_ff[1];
   assign rsp_skinned_z = out_ff[2];
   assign rsp_used_fallback = fb_ff;
endmodule

### src/linear_blend_vertex_skinning.sv
// top level of the four bone linear blend skinning block
//  channel | dir | handshake   | carries
//  req     | in  | valid/ready | matrix word write or vertex to skin
//  rsp     | out | valid/ready | skinned vertex and fallback flag
// a word write is accepted, then written to the memory
// a vertex is accepted, then each matrix word read passes through read,
// multiply and two accumulate halves (12 words per counted influence), each
// skipped influence takes a step of its own, and then the result is formed
// reset is synchronous; the matrix memory is not cleared
// a new item is accepted while a result waits; its result cycle stalls until taken
module linear_blend_vertex_skinning
   import lbs_pkg::*;
#(
   parameter int NUM_BONES = NumBonesDefault,
   parameter int INFLUENCES = InfluencesDefault
) (
   input logic clock,
   input logic reset,
   lbs_req_if.sink   req,
   lbs_rsp_if.source rsp
);
`include "linear_blend_vertex_skinning_assert.svh"
   cmd_type cmd;
   status_type status;
   logic [1:0] infl, row, col;

   lbs_ctrl #(.INFLUENCES(INFLUENCES)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status, .cmd, .infl, .row, .col
   );

   lbs_dp #(.NUM_BONES(NUM_BONES)) u_dp (
      .clock, .cmd, .infl, .row, .col,
      .req_func(req.func), .req_bone_index(req.bone_index),
      .req_element_index(req.element_index), .req_element_value(req.element_value),
      .req_vertex_tag(req.vertex_tag), .req_pos_x(req.pos_x), .req_pos_y(req.pos_y),
      .req_pos_z(req.pos_z), .req_bone_ids_packed(req.bone_ids_packed),
      .req_weights_packed(req.weights_packed), .status,
      .rsp_vertex_tag_out(rsp.vertex_tag_out), .rsp_skinned_x(rsp.skinned_x),
      .rsp_skinned_y(rsp.skinned_y), .rsp_skinned_z(rsp.skinned_z),
      .rsp_used_fallback(rsp.used_fallback)
   );

   `LBS_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp.valid)
   `LBS_ASSERT_SAME(a_no_mem_clash, clock, reset, cmd.write_mem, !cmd.read)
   `LBS_ASSERT_NEXT(a_read_then_mul, clock, reset, cmd.read, cmd.mul)
endmodule

### tb/linear_blend_vertex_skinning_test.sv
// self-checking testbench for the four bone linear blend skinning block
module linear_blend_vertex_skinning_test;
   import lbs_pkg::*;

   localparam int NumBones = NumBonesDefault;
   localparam int NumWords = NumBones * WordsPerBone;

   typedef struct {
      func_type           func;
      logic [6:0]         bone_index;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic [23:0]        vertex_tag;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        bone_ids_packed;
      logic [63:0]        weights_packed;
   } skin_request_type;

   typedef struct {
      logic [23:0]        tag;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               fallback;
   } skinned_vertex_type;

   logic clock;
   logic reset;

   lbs_req_if req_ch ();
   lbs_rsp_if rsp_ch ();

   linear_blend_vertex_skinning i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // shadow of the bone matrix table
   logic [31:0]        matrix_words [NumWords];
   bit                 word_written [NumWords];
   skinned_vertex_type pending_vertices [$];
   int                 error_count;
   bit                 hold_request;
   bit                 no_idle;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #12000000;
      $display("linear_blend_vertex_skinning_test: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, want %h", what, got, want);
      error_count++;
   endtask

   // a bone is usable once every word that reaches a result has been written
   function automatic bit bone_loaded(input int bone);
      bit ok;
      ok = 1'b1;
      for (int e = 0; e < WordsPerBone; e++)
         if ((e % 4) != 3 && !word_written[bone * WordsPerBone + e]) ok = 1'b0;
      return ok;
   endfunction

   // weighted matrix blend applied to the bind position
   function automatic skinned_vertex_type blend_vertex(input skin_request_type it);
      skinned_vertex_type res;
      logic signed [99:0] acc [3];
      logic signed [99:0] pos [3];
      logic signed [99:0] term, weight, rounded;
      logic signed [31:0] word;
      logic [7:0]         id;
      int                 total;
      pos[0] = it.pos_x;
      pos[1] = it.pos_y;
      pos[2] = it.pos_z;
      total = 0;
      for (int r = 0; r < 3; r++) acc[r] = '0;
      for (int i = 0; i < InfluencesDefault; i++) begin
         id = it.bone_ids_packed[8*i +: 8];
         weight = {84'b0, it.weights_packed[16*i +: 16]};
         if (id < NumBones && weight != 0) begin
            for (int r = 0; r < 3; r++) begin
               term = '0;
               for (int c = 0; c < 3; c++) begin
                  word = matrix_words[id * WordsPerBone + c * 4 + r];
                  term = term + 100'(word) * pos[c];
               end
               word = matrix_words[id * WordsPerBone + 12 + r];
               term = term + 100'(word) * 100'sd65536;
               acc[r] = acc[r] + term * weight;
            end
            total += int'(it.weights_packed[16*i +: 16]);
         end
      end
      res.tag = it.vertex_tag;
      if (total < MinTotalWeight) begin
         res.x = it.pos_x;
         res.y = it.pos_y;
         res.z = it.pos_z;
         res.fallback = 1'b1;
      end else begin
         for (int r = 0; r < 3; r++) begin
            rounded = (acc[r] + (100'sd1 <<< 30)) >>> 31;
            if (rounded > 100'sd2147483647) word = 32'h7FFFFFFF;
            else if (rounded < -100'sd2147483648) word = 32'h80000000;
            else word = rounded[31:0];
            if (r == 0) res.x = word;
            else if (r == 1) res.y = word;
            else res.z = word;
         end
         res.fallback = 1'b0;
      end
      return res;
   endfunction

   function automatic int gap_length();
      if (no_idle || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one item and wait for its transfer
   task automatic send_item(input skin_request_type it);
      int gap;
      gap = gap_length();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid         = 1'b1;
      req_ch.func          = it.func;
      req_ch.bone_index    = it.bone_index;
      req_ch.element_index = it.element_index;
      req_ch.element_value = it.element_value;
      req_ch.vertex_tag    = it.vertex_tag;
      req_ch.pos_x         = it.pos_x;
      req_ch.pos_y         = it.pos_y;
      req_ch.pos_z         = it.pos_z;
      req_ch.bone_ids_packed = it.bone_ids_packed;
      req_ch.weights_packed  = it.weights_packed;
      do @(posedge clock); while (!req_ch.ready);
      if (it.func == FUNC_WRITE) begin
         matrix_words[it.bone_index * WordsPerBone + it.element_index] = it.element_value;
         word_written[it.bone_index * WordsPerBone + it.element_index] = 1'b1;
      end else begin
         pending_vertices.push_back(blend_vertex(it));
      end
   endtask

   task automatic write_word(input int bone, input int elem, input logic [31:0] value);
      skin_request_type it;
      it.func = FUNC_WRITE;
      it.bone_index = 7'(bone);
      it.element_index = 4'(elem);
      it.element_value = value;
      it.vertex_tag = 24'($urandom);
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
      it.bone_ids_packed = $urandom;
      it.weights_packed = {$urandom, $urandom};
      send_item(it);
   endtask

   task automatic skin(input logic [23:0] tag, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z, input logic [31:0] ids, input logic [63:0] w);
      skin_request_type it;
      it.func = FUNC_SKIN;
      it.bone_index = 7'($urandom);
      it.element_index = 4'($urandom);
      it.element_value = $urandom;
      it.vertex_tag = tag;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      it.bone_ids_packed = ids;
      it.weights_packed = w;
      send_item(it);
   endtask

   // bone 0 near identity, bone 1 at the word extremes, bone 127 random
   task automatic test_matrix_load();
      for (int e = 0; e < WordsPerBone; e++) begin
         write_word(0, e, (e % 5 == 0) ? 32'h00010000 : (e >= 12 ? 32'h00020000 : 32'h0));
         write_word(1, e, e[0] ? 32'h80000000 : 32'h7FFFFFFF);
         write_word(127, e, $urandom);
      end
   endtask

   // extremes, weight thresholds, skipped influences
   task automatic test_edges();
      skin(24'h000000, 32'h00010000, 32'hFFFF0000, 32'h00008000, 32'h0, 64'h8000);
      skin(24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h01, 64'hFFFF);
      skin(24'h123456, 32'h80000000, 32'h80000000, 32'h80000000, 32'h01, 64'hFFFF);
      skin(24'h000001, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7F01_007F, 64'hFFFF_FFFF_FFFF_FFFF);
      skin(24'h000002, 32'h12345678, 32'h9ABCDEF0, 32'h0, 32'h0, 64'h20);
      skin(24'h000003, 32'h12345678, 32'h9ABCDEF0, 32'h1, 32'h0, 64'h21);
      skin(24'h000004, 32'h00030000, 32'h1, 32'h2, 32'h0000_7F00, 64'h0000_0000_0010_0011);
      skin(24'h000005, 32'h7FFFFFFF, 32'h1, 32'h2, 32'h4050_6070, 64'h0);
      skin(24'h000006, 32'h80000000, 32'h3, 32'h4, 32'hFF80_81C0, 64'hFFFF_FFFF_FFFF_FFFF);
      skin(24'h000007, 32'h00050000, 32'h6, 32'h7, 32'h0180_7F00, 64'h0000_4000_FFFF_4000);
      skin(24'h000008, 32'h00050000, 32'h6, 32'h7, 32'h0000_0000, 64'h0001_0001_0001_001D);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_request = 1'b1;
      for (int n = 0; n < 40; n++)
         skin(24'($urandom), $urandom, $urandom, $urandom, {8'd127, 8'd1, 8'd0, 8'd127},
              {$urandom, $urandom});
      no_idle = 1'b0;
   endtask

   function automatic logic [7:0] pick_bone_id(output bit need_zero);
      int b;
      need_zero = 1'b0;
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(NumBones, 255));
         1: begin
            need_zero = 1'b1;
            return 8'($urandom);
         end
         default: begin
            repeat (20) begin
               b = $urandom_range(0, NumBones - 1);
               if (bone_loaded(b)) return 8'(b);
            end
            return 8'($urandom_range(0, 1));
         end
      endcase
   endfunction

   task automatic test_random();
      logic [31:0] ids;
      logic [63:0] w;
      logic [15:0] wi;
      logic [7:0]  id;
      bit          zero_w;
      int          bone;
      for (int n = 0; n < 1050; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            bone = $urandom_range(0, 9) < 7 ? $urandom_range(0, 15) : $urandom_range(0, 127);
            write_word(bone, $urandom_range(0, 15),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h3FFFF) - 32'h1FFFF);
         end else begin
            for (int i = 0; i < InfluencesDefault; i++) begin
               id = pick_bone_id(zero_w);
               case ($urandom_range(0, 5))
                  0: wi = 16'($urandom);
                  1: wi = 16'($urandom_range(0, 40));
                  2: wi = 16'h0;
                  default: wi = 16'($urandom_range(0, 16'h8000));
               endcase
               if (id < NumBones && !bone_loaded(id)) zero_w = 1'b1;
               ids[8*i +: 8] = id;
               w[16*i +: 16] = zero_w ? 16'h0 : wi;
            end
            if ($urandom_range(0, 3) == 0)
               skin(24'($urandom), $urandom, $urandom, $urandom, ids, w);
            else
               skin(24'($urandom), $urandom_range(0, 32'hFFFFF) - 32'h7FFFF,
                    $urandom_range(0, 32'hFFFFF) - 32'h7FFFF,
                    $urandom_range(0, 32'hFFFFF) - 32'h7FFFF, ids, w);
         end
      end
   endtask

   // result side ready, with random gaps and a long hold on request
   initial begin
      int gap;
      int hold;
      gap = 0;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready = 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
            gap = gap_length();
         end
      end
   end

   // compare each result transfer with the oldest expected vertex
   always @(posedge clock) begin
      skinned_vertex_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected result tag", 32'(rsp_ch.vertex_tag_out), 32'h0);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_ch.vertex_tag_out !== want.tag)
               report_mismatch("vertex_tag_out", 32'(rsp_ch.vertex_tag_out), 32'(want.tag));
            if (rsp_ch.skinned_x !== want.x) report_mismatch("skinned_x", rsp_ch.skinned_x, want.x);
            if (rsp_ch.skinned_y !== want.y) report_mismatch("skinned_y", rsp_ch.skinned_y, want.y);
            if (rsp_ch.skinned_z !== want.z) report_mismatch("skinned_z", rsp_ch.skinned_z, want.z);
            if (rsp_ch.used_fallback !== want.fallback)
               report_mismatch("used_fallback", 32'(rsp_ch.used_fallback), 32'(want.fallback));
         end
      end
   end

   // main sequence
   initial begin
      error_count = 0;
      hold_request = 1'b0;
      no_idle = 1'b0;
      for (int k = 0; k < NumWords; k++) begin
         matrix_words[k] = '0;
         word_written[k] = 1'b0;
      end
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_WRITE;
      req_ch.bone_index = '0;
      req_ch.element_index = '0;
      req_ch.element_value = '0;
      req_ch.vertex_tag = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      req_ch.bone_ids_packed = '0;
      req_ch.weights_packed = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_matrix_load();
      test_edges();
      test_backpressure();
      test_random();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("linear_blend_vertex_skinning_test: done, clean");
      else
         $display("linear_blend_vertex_skinning_test: done, errors");
      $finish;
   end
endmodule

### linear_blend_vertex_skinning.f
+incdir+src
src/lbs_pkg.sv
src/lbs_if.sv
src/lbs_ctrl.sv
src/lbs_dp.sv
src/linear_blend_vertex_skinning.sv
tb/linear_blend_vertex_skinning_test.sv
